### rtl/core/usbog_pkg.sv
package usbog_pkg;

  // Field widths
  localparam int TEMP_W  = 10;
  localparam int BATT_W  = 12;
  localparam int DIFF_W  = 11;
  localparam int CNT_W   = 12;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [BATT_W-1:0] batt_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [CNT_W-1:0]  cnt_t;
  typedef logic [KIND_W-1:0]        kind_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Default counter limits
  localparam int INSERT_COUNT_DEF = 1100;
  localparam int END_COUNT_DEF    = 1001;

  // Reciprocal of ten: floor(a * 3277 / 2^15) equals floor(a / 10) for a up to 2048.
  localparam int RECIP_10    = 3277;
  localparam int RECIP_SHIFT = 15;
  localparam int QUOT_W      = 8;

  // Request kinds
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_CHARGER = 1'b1;

  // Charger kinds
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_USB  = 2'd1;

  // Configuration register indexes
  localparam cfg_idx_t CFG_GUARD_ENABLE      = 3'd0;
  localparam cfg_idx_t CFG_PROTECT_CONN_TEMP = 3'd1;
  localparam cfg_idx_t CFG_RECOVER_CONN_TEMP = 3'd2;
  localparam cfg_idx_t CFG_OPEN_DIFF_TEMP    = 3'd3;
  localparam cfg_idx_t CFG_CLOSE_DIFF_TEMP   = 3'd4;
  localparam cfg_idx_t CFG_FAST_SWITCH_DIFF  = 3'd5;

  // Configuration reset values
  localparam temp_t PROTECT_CONN_TEMP_RST = 10'sd70;
  localparam temp_t RECOVER_CONN_TEMP_RST = 10'sd60;
  localparam temp_t OPEN_DIFF_TEMP_RST    = 10'sd25;
  localparam temp_t CLOSE_DIFF_TEMP_RST   = 10'sd15;
  localparam temp_t FAST_SWITCH_DIFF_RST  = 10'sd10;

  // Counter value that marks the idle counter
  localparam cnt_t CNT_IDLE = -12'sd1;

endpackage

### rtl/core/usbog_in_if.sv
interface usbog_in_if;
  logic                  valid;
  logic                  ready;
  logic                  func;
  usbog_pkg::temp_t      conn_temp;
  usbog_pkg::batt_t      batt_temp_tenths;
  logic                  batt_valid;
  usbog_pkg::kind_t      charger_kind;

  modport source (
    output valid, func, conn_temp, batt_temp_tenths, batt_valid, charger_kind,
    input  ready
  );
  modport sink (
    input  valid, func, conn_temp, batt_temp_tenths, batt_valid, charger_kind,
    output ready
  );
endinterface

### rtl/core/usbog_out_if.sv
interface usbog_out_if;
  logic valid;
  logic ready;
  logic switch_open;
  logic fast_rate;
  logic protect_mode;
  logic monitoring;
  logic wake_hold;

  modport source (
    output valid, switch_open, fast_rate, protect_mode, monitoring, wake_hold,
    input  ready
  );
  modport sink (
    input  valid, switch_open, fast_rate, protect_mode, monitoring, wake_hold,
    output ready
  );
endinterface

### rtl/core/usb_port_overtemp_guard.sv
// A request passes through the input register and then the result register. Throughput: one
// request per cycle unless out_ch.ready stalls; the input and result registers form a
// two-stage pipeline, and the guard state is updated once per request in the second stage.
// Reset (rst_n, synchronous, active low) empties both stages, loads the configuration
// registers with their defaults and puts the guard in its idle state with the counter loaded.
module usb_port_overtemp_guard #(
  parameter int INSERT_COUNT = usbog_pkg::INSERT_COUNT_DEF,
  parameter int END_COUNT    = usbog_pkg::END_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  usbog_in_if.sink                      in_ch,
  usbog_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  usbog_pkg::cfg_idx_t           cfg_index,
  input  logic [usbog_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam usbog_pkg::cnt_t INSERT_CNT = usbog_pkg::cnt_t'(INSERT_COUNT);
  localparam usbog_pkg::cnt_t END_CNT    = usbog_pkg::cnt_t'(END_COUNT);
  localparam int PROD_W = usbog_pkg::BATT_W + 13;

  // Configuration registers.
  logic             guard_enable_r;
  usbog_pkg::temp_t protect_conn_temp_r;
  usbog_pkg::temp_t recover_conn_temp_r;
  usbog_pkg::temp_t open_diff_temp_r;
  usbog_pkg::temp_t close_diff_temp_r;
  usbog_pkg::temp_t fast_switch_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_enable_r      <= 1'b0;
      protect_conn_temp_r <= usbog_pkg::PROTECT_CONN_TEMP_RST;
      recover_conn_temp_r <= usbog_pkg::RECOVER_CONN_TEMP_RST;
      open_diff_temp_r    <= usbog_pkg::OPEN_DIFF_TEMP_RST;
      close_diff_temp_r   <= usbog_pkg::CLOSE_DIFF_TEMP_RST;
      fast_switch_diff_r  <= usbog_pkg::FAST_SWITCH_DIFF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        usbog_pkg::CFG_GUARD_ENABLE:      guard_enable_r      <= cfg_wdata[0];
        usbog_pkg::CFG_PROTECT_CONN_TEMP: protect_conn_temp_r <= cfg_wdata;
        usbog_pkg::CFG_RECOVER_CONN_TEMP: recover_conn_temp_r <= cfg_wdata;
        usbog_pkg::CFG_OPEN_DIFF_TEMP:    open_diff_temp_r    <= cfg_wdata;
        usbog_pkg::CFG_CLOSE_DIFF_TEMP:   close_diff_temp_r   <= cfg_wdata;
        usbog_pkg::CFG_FAST_SWITCH_DIFF:  fast_switch_diff_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline handshake. The result register advances when it is empty or being taken,
  // and the input register advances into it at the same time, so a fresh request is
  // taken while a finished result still waits downstream only if the input register is empty.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_adv;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_adv;
  assign in_ch.ready = !s1_valid_r || out_adv;

  // Input register.
  logic             s1_func_r;
  usbog_pkg::temp_t s1_conn_temp_r;
  usbog_pkg::batt_t s1_batt_r;
  logic             s1_batt_valid_r;
  usbog_pkg::kind_t s1_kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_func_r       <= in_ch.func;
      s1_conn_temp_r  <= in_ch.conn_temp;
      s1_batt_r       <= in_ch.batt_temp_tenths;
      s1_batt_valid_r <= in_ch.batt_valid;
      s1_kind_r       <= in_ch.charger_kind;
    end
  end

  // Battery temperature in whole degrees, truncated toward zero. The magnitude is scaled
  // by a reciprocal of ten and the sign put back afterwards.
  logic [usbog_pkg::BATT_W-1:0]   batt_mag;
  logic [PROD_W-1:0]              batt_prod;
  logic [usbog_pkg::QUOT_W-1:0]   batt_quot;
  usbog_pkg::diff_t               batt_deg;
  usbog_pkg::diff_t               diff;

  always_comb begin
    batt_mag  = s1_batt_r[usbog_pkg::BATT_W-1] ? (~s1_batt_r + 1'b1) : s1_batt_r;
    batt_prod = PROD_W'(batt_mag) * PROD_W'(usbog_pkg::RECIP_10);
    batt_quot = batt_prod[usbog_pkg::RECIP_SHIFT +: usbog_pkg::QUOT_W];
    batt_deg  = s1_batt_r[usbog_pkg::BATT_W-1]
                ? -usbog_pkg::diff_t'({1'b0, batt_quot})
                :  usbog_pkg::diff_t'({1'b0, batt_quot});
    diff      = s1_batt_valid_r
                ? (usbog_pkg::diff_t'(s1_conn_temp_r) - batt_deg)
                : '0;
  end

  // Guard state.
  usbog_pkg::cnt_t check_count_r, check_count_nxt;
  logic switch_r,  switch_nxt;
  logic rate_r,    rate_nxt;
  logic mode_r,    mode_nxt;
  logic running_r, running_nxt;
  logic wake_r,    wake_nxt;

  // One step of the guard. On a tick the counter and rate are settled first, then the
  // switch, so a switch opening in the same tick as the end of the count sets the wake
  // flag again after the count released it.
  always_comb begin
    check_count_nxt = check_count_r;
    switch_nxt      = switch_r;
    rate_nxt        = rate_r;
    mode_nxt        = mode_r;
    running_nxt     = running_r;
    wake_nxt        = wake_r;

    if (s1_func_r == usbog_pkg::FUNC_CHARGER) begin
      if (guard_enable_r && (s1_kind_r == usbog_pkg::KIND_USB) && !running_r) begin
        check_count_nxt = INSERT_CNT;
        running_nxt     = 1'b1;
      end
    end else if (running_r) begin
      if ((check_count_r == usbog_pkg::CNT_IDLE) && (s1_kind_r == usbog_pkg::KIND_NONE)) begin
        // Charger gone with the counter idle: stop monitoring.
        switch_nxt      = 1'b0;
        rate_nxt        = 1'b0;
        mode_nxt        = 1'b0;
        check_count_nxt = INSERT_CNT;
        running_nxt     = 1'b0;
      end else begin
        if (diff > usbog_pkg::diff_t'(fast_switch_diff_r)) begin
          // Hot excursion restarts the count from zero in protect mode.
          rate_nxt        = 1'b1;
          check_count_nxt = '0;
          mode_nxt        = 1'b1;
        end else if (check_count_r > END_CNT) begin
          check_count_nxt = check_count_r - 1'b1;
          rate_nxt        = 1'b1;
          mode_nxt        = 1'b0;
        end else if (check_count_r == END_CNT) begin
          check_count_nxt = usbog_pkg::CNT_IDLE;
          rate_nxt        = 1'b0;
          mode_nxt        = 1'b0;
          wake_nxt        = 1'b0;
        end else if (!check_count_r[usbog_pkg::CNT_W-1]) begin
          check_count_nxt = check_count_r + 1'b1;
          rate_nxt        = 1'b1;
          mode_nxt        = 1'b1;
        end else begin
          rate_nxt = 1'b0;
          mode_nxt = 1'b0;
        end

        // Switch with hysteresis between the open and close thresholds.
        if ((diff >= usbog_pkg::diff_t'(open_diff_temp_r)) &&
            (s1_conn_temp_r >= protect_conn_temp_r)) begin
          wake_nxt   = 1'b1;
          switch_nxt = 1'b1;
        end else if ((diff <= usbog_pkg::diff_t'(close_diff_temp_r)) &&
                     (s1_conn_temp_r <= recover_conn_temp_r)) begin
          switch_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_count_r <= INSERT_CNT;
      switch_r      <= 1'b0;
      rate_r        <= 1'b0;
      mode_r        <= 1'b0;
      running_r     <= 1'b0;
      wake_r        <= 1'b0;
    end else if (s1_adv) begin
      check_count_r <= check_count_nxt;
      switch_r      <= switch_nxt;
      rate_r        <= rate_nxt;
      mode_r        <= mode_nxt;
      running_r     <= running_nxt;
      wake_r        <= wake_nxt;
    end
  end

  // Result register: the state as it stands after the request.
  logic out_switch_r;
  logic out_rate_r;
  logic out_mode_r;
  logic out_running_r;
  logic out_wake_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_switch_r  <= switch_nxt;
      out_rate_r    <= rate_nxt;
      out_mode_r    <= mode_nxt;
      out_running_r <= running_nxt;
      out_wake_r    <= wake_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.switch_open  = out_switch_r;
  assign out_ch.fast_rate    = out_rate_r;
  assign out_ch.protect_mode = out_mode_r;
  assign out_ch.monitoring   = out_running_r;
  assign out_ch.wake_hold    = out_wake_r;

endmodule
